// ===== design/sbtld_pkg.sv =====
// shared types, codes and case tables for the six-bit text line decoder
// no dependencies

package sbtld_pkg;

  localparam int CODE_W         = 6;
  localparam int CHAR_W         = 7;
  localparam int QDEPTH_DEFAULT = 4;

  localparam logic [CODE_W-1:0] CODE_BLANK     = 6'o00;
  localparam logic [CODE_W-1:0] CODE_SHIFT_UP  = 6'o70;
  localparam logic [CODE_W-1:0] CODE_SHIFT_LOW = 6'o71;
  localparam logic [CODE_W-1:0] CODE_SHIFT_CTL = 6'o72;
  localparam logic [CHAR_W-1:0] SPACE_CHAR     = 7'h20;

  typedef enum logic [1:0] {
    UPPER_SET = 2'd0,
    LOWER_SET = 2'd1,
    CTRL_SET  = 2'd2
  } case_t;

  // one queued command: a single character or a run of spaces
  typedef struct packed {
    logic              is_run;
    logic [CHAR_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
    cmd_t head;
  } q_status_t;

  localparam logic [CHAR_W-1:0] TAB_UPPER [0:63] = '{
    7'h00, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47,
    7'h48, 7'h49, 7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F,
    7'h50, 7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57,
    7'h58, 7'h59, 7'h5A, 7'h30, 7'h31, 7'h32, 7'h33, 7'h34,
    7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h2B, 7'h2D, 7'h2A,
    7'h2F, 7'h28, 7'h29, 7'h24, 7'h3D, 7'h20, 7'h2C, 7'h2E,
    7'h23, 7'h5B, 7'h5D, 7'h3A, 7'h22, 7'h5F, 7'h21, 7'h26,
    7'h27, 7'h3F, 7'h3C, 7'h3E, 7'h40, 7'h5C, 7'h5E, 7'h3B
  };

  localparam logic [CHAR_W-1:0] TAB_LOWER [0:63] = '{
    7'h00, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67,
    7'h68, 7'h69, 7'h6A, 7'h6B, 7'h6C, 7'h6D, 7'h6E, 7'h6F,
    7'h70, 7'h71, 7'h72, 7'h73, 7'h74, 7'h75, 7'h76, 7'h77,
    7'h78, 7'h79, 7'h7A, 7'h30, 7'h31, 7'h32, 7'h33, 7'h34,
    7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h2B, 7'h2D, 7'h2A,
    7'h2F, 7'h28, 7'h29, 7'h24, 7'h3D, 7'h20, 7'h2C, 7'h2E,
    7'h27, 7'h3F, 7'h3C, 7'h3E, 7'h40, 7'h5C, 7'h5E, 7'h3B,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [CHAR_W-1:0] TAB_CTL [0:63] = '{
    7'h00, 7'h01, 7'h02, 7'h03, 7'h04, 7'h05, 7'h06, 7'h07,
    7'h08, 7'h09, 7'h0A, 7'h0B, 7'h0C, 7'h0D, 7'h0E, 7'h0F,
    7'h10, 7'h11, 7'h12, 7'h13, 7'h14, 7'h15, 7'h16, 7'h17,
    7'h18, 7'h19, 7'h1A, 7'h1B, 7'h1C, 7'h1D, 7'h1E, 7'h1F,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h5F,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h25, 7'h60, 7'h7B, 7'h7C, 7'h7D, 7'h7E, 7'h7F,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  function automatic logic [CHAR_W-1:0] case_lookup(case_t c, logic [CODE_W-1:0] code);
    case (c)
      LOWER_SET: return TAB_LOWER[code];
      CTRL_SET:  return TAB_CTL[code];
      default:   return TAB_UPPER[code];
    endcase
  endfunction

endpackage

// ===== design/sbtld_front.sv =====
// front end: accepts codes, tracks case and blank compression, issues commands
// depends on sbtld_pkg

module sbtld_front import sbtld_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [CODE_W-1:0] char_code,
  input  logic              line_start,
  input  q_status_t         q_status,
  output logic              full,
  output logic              enq,
  output cmd_t              enq_cmd
);

  case_t cur_case, cur_case_next, case_eff;
  logic  pending, pending_next, pending_eff;
  logic  accept;

  assign full   = q_status.full;
  assign accept = push & ~q_status.full;

  always_comb begin
    case_eff      = line_start ? UPPER_SET : cur_case;
    pending_eff   = line_start ? 1'b0 : pending;
    cur_case_next = cur_case;
    pending_next  = pending;
    enq           = 1'b0;
    enq_cmd       = '{is_run: 1'b0, data: case_lookup(case_eff, char_code)};
    if (accept) begin
      cur_case_next = case_eff;
      pending_next  = pending_eff;
      if (pending_eff) begin
        // code is a blank count
        pending_next = 1'b0;
        enq          = (char_code != '0);
        enq_cmd      = '{is_run: 1'b1, data: {1'b0, char_code}};
      end else begin
        case (char_code)
          CODE_BLANK:     pending_next  = 1'b1;
          CODE_SHIFT_UP:  cur_case_next = UPPER_SET;
          CODE_SHIFT_LOW: cur_case_next = LOWER_SET;
          CODE_SHIFT_CTL: cur_case_next = CTRL_SET;
          default:        enq           = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_case <= UPPER_SET;
      pending  <= 1'b0;
    end else begin
      cur_case <= cur_case_next;
      pending  <= pending_next;
    end
  end

endmodule

// ===== design/sbtld_queue.sv =====
// command queue between front and back ends
// depends on sbtld_pkg

module sbtld_queue import sbtld_pkg::*; #(
  parameter int DEPTH = QDEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      enq,
  input  cmd_t      enq_cmd,
  input  logic      deq,
  output q_status_t q_status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_enq, do_deq;

  assign q_status.valid = (count != '0);
  assign q_status.full  = (count == CNT_W'(DEPTH));
  assign q_status.head  = slots[rd_ptr];
  assign do_enq = enq & ~q_status.full;
  assign do_deq = deq & q_status.valid;

  always_ff @(posedge clk) begin
    if (do_enq) begin
      slots[wr_ptr] <= enq_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_enq) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_deq) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_enq) - CNT_W'(do_deq);
    end
  end

endmodule

// ===== design/sbtld_back.sv =====
// back end: expands commands into output words, holds the output register
// depends on sbtld_pkg

module sbtld_back import sbtld_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  q_status_t         q_status,
  input  logic              pop,
  output logic              deq,
  output logic              empty,
  output logic [CHAR_W-1:0] ascii_char,
  output logic              last_of_run
);

  logic              out_valid, out_valid_next;
  logic [CHAR_W-1:0] out_char, out_char_next;
  logic              out_last, out_last_next;
  logic [CODE_W-1:0] run_left, run_left_next;
  logic              can_load;

  assign empty       = ~out_valid;
  assign ascii_char  = out_char;
  assign last_of_run = out_last;
  assign can_load    = ~out_valid | pop;

  always_comb begin
    out_valid_next = out_valid;
    out_char_next  = out_char;
    out_last_next  = out_last;
    run_left_next  = run_left;
    deq            = 1'b0;
    if (can_load) begin
      out_valid_next = 1'b0;
      if (run_left != '0) begin
        out_valid_next = 1'b1;
        out_char_next  = SPACE_CHAR;
        out_last_next  = (run_left == CODE_W'(1));
        run_left_next  = run_left - 1'b1;
      end else if (q_status.valid) begin
        deq            = 1'b1;
        out_valid_next = 1'b1;
        if (q_status.head.is_run) begin
          out_char_next = SPACE_CHAR;
          out_last_next = (q_status.head.data[CODE_W-1:0] == CODE_W'(1));
          run_left_next = q_status.head.data[CODE_W-1:0] - 1'b1;
        end else begin
          out_char_next = q_status.head.data;
          out_last_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_char <= out_char_next;
    out_last <= out_last_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      run_left  <= '0;
    end else begin
      out_valid <= out_valid_next;
      run_left  <= run_left_next;
    end
  end

endmodule

// ===== design/six_bit_text_line_decoder.sv =====
// top level of the six-bit text line decoder
// depends on sbtld_pkg, sbtld_front, sbtld_queue, sbtld_back
//
//   channel  handshake    fields
//   input    push / full  char_code[5:0], line_start
//   result   empty / pop  ascii_char[6:0], last_of_run
//
// each code is taken when pushed; the front end never waits except on a full queue
// on pop the back end gives one word per cycle: one per character, n per blank run of n
// shift codes, the blank marker and a zero count give no word and leave the queue alone
// while popped, sustained output rate is one word per cycle, set by the back end
// synchronous reset clears case and compression and empties queue and output register
// a stalled result only blocks input once the queue of QUEUE_DEPTH commands is full

module six_bit_text_line_decoder import sbtld_pkg::*; #(
  parameter int QUEUE_DEPTH = QDEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [CODE_W-1:0] char_code,
  input  logic              line_start,
  output logic              empty,
  input  logic              pop,
  output logic [CHAR_W-1:0] ascii_char,
  output logic              last_of_run
);

  q_status_t q_status;
  cmd_t      enq_cmd;
  logic      enq, deq;

  sbtld_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .char_code  (char_code),
    .line_start (line_start),
    .q_status   (q_status),
    .full       (full),
    .enq        (enq),
    .enq_cmd    (enq_cmd)
  );

  sbtld_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .enq      (enq),
    .enq_cmd  (enq_cmd),
    .deq      (deq),
    .q_status (q_status)
  );

  sbtld_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .pop         (pop),
    .deq         (deq),
    .empty       (empty),
    .ascii_char  (ascii_char),
    .last_of_run (last_of_run)
  );

endmodule

// ===== design/sbtld_checker.sv =====
// port-level checks for the six-bit text line decoder
// depends on sbtld_pkg; bound to six_bit_text_line_decoder

module sbtld_checker import sbtld_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              push,
  input logic              full,
  input logic [CODE_W-1:0] char_code,
  input logic              line_start,
  input logic              empty,
  input logic              pop,
  input logic [CHAR_W-1:0] ascii_char,
  input logic              last_of_run
);

  // nothing waits right after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queue or output not clear after reset");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(ascii_char) && $stable(last_of_run)))
    else $error("stalled word changed");

  // only blank runs give words that are not last
  a_run_space: assert property (@(posedge clk) disable iff (rst)
    (!empty && !last_of_run) |-> (ascii_char == SPACE_CHAR))
    else $error("non-last word is not a space");

  // a blank run continues without a gap
  a_run_gapless: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last_of_run) |=> !empty)
    else $error("gap inside blank run");

endmodule

bind six_bit_text_line_decoder sbtld_checker u_chk (.*);
